// ----- sv/mgrt_pkg.sv -----
// shared types and constants for the minimum gap and range tracker
// no dependencies; used by every design module of the block

package mgrt_pkg;

	localparam int WORD_W = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int LIMIT_W = 9;

	localparam logic [ADDR_W-1:0] ADDR_LIMIT = 3'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd100;

	localparam logic [WORD_W-1:0] GAP_INIT = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] MIN_INIT = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MAX_INIT = 32'h8000_0000;

	// one number travelling down the cell chain
	typedef struct packed {
		logic vld;
		logic take;
		logic two;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] gap;
	} tok_t;

endpackage

// ----- sv/mgrt_cfg.sv -----
// register port: holds the limit register behind an apb-style slave
// depends on mgrt_pkg

module mgrt_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mgrt_pkg::ADDR_W-1:0] paddr,
	input  logic [mgrt_pkg::DATA_W-1:0] pwdata,
	output logic [mgrt_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [mgrt_pkg::LIMIT_W-1:0] limit_q
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr == mgrt_pkg::ADDR_LIMIT);

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mgrt_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[mgrt_pkg::LIMIT_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr == mgrt_pkg::ADDR_LIMIT) begin
			prdata = {{(mgrt_pkg::DATA_W - mgrt_pkg::LIMIT_W){1'b0}}, limit_q};
		end
	end

endmodule

// ----- sv/mgrt_cell.sv -----
// one chain cell: holds one stored number, folds its gap to the passing beat
// depends on mgrt_pkg

module mgrt_cell #(
	parameter int CAPACITY = 256,
	parameter int INDEX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  mgrt_pkg::tok_t tok_in,
	input  logic [$clog2(CAPACITY)-1:0] slot_in,
	output mgrt_pkg::tok_t tok_q,
	output logic [$clog2(CAPACITY)-1:0] slot_q
);

	localparam int SW = $clog2(CAPACITY);

	logic [mgrt_pkg::WORD_W-1:0] stored_q;
	logic [mgrt_pkg::WORD_W:0] d_ab;
	logic [mgrt_pkg::WORD_W:0] d_ba;
	logic [mgrt_pkg::WORD_W-1:0] mag;
	logic cmp_en;
	logic wr_en;
	mgrt_pkg::tok_t tok_nxt;

	// exact signed difference both ways, pick the non-negative one
	assign d_ab = {tok_in.value[mgrt_pkg::WORD_W-1], tok_in.value}
		- {stored_q[mgrt_pkg::WORD_W-1], stored_q};
	assign d_ba = {stored_q[mgrt_pkg::WORD_W-1], stored_q}
		- {tok_in.value[mgrt_pkg::WORD_W-1], tok_in.value};
	assign mag = d_ab[mgrt_pkg::WORD_W] ? d_ba[mgrt_pkg::WORD_W-1:0]
		: d_ab[mgrt_pkg::WORD_W-1:0];

	// only cells already filled take part; the cell at the slot stores the number
	assign cmp_en = tok_in.vld && tok_in.take && (SW'(INDEX) < slot_in);
	assign wr_en = tok_in.vld && tok_in.take && (SW'(INDEX) == slot_in);

	always_comb begin
		tok_nxt = tok_in;
		if (cmp_en && (mag < tok_in.gap)) begin
			tok_nxt.gap = mag;
		end
	end

	// hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			slot_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			slot_q <= slot_in;
		end
	end

	// stored number, written once when its slot comes by
	always_ff @(posedge clk) begin
		if (adv && wr_en) begin
			stored_q <= tok_in.value;
		end
	end

endmodule

// ----- sv/mgrt_tail.sv -----
// chain tail: folds the beat into running min, max and best gap, drives results
// depends on mgrt_pkg

module mgrt_tail (
	input  logic clk,
	input  logic arst_n,
	input  mgrt_pkg::tok_t tok_in,
	input  logic out_ready,
	output logic adv,
	output logic out_valid,
	output logic accepted,
	output logic overflow,
	output logic too_few,
	output logic [mgrt_pkg::WORD_W-1:0] shortest_span,
	output logic [mgrt_pkg::WORD_W-1:0] longest_span
);

	logic [mgrt_pkg::WORD_W-1:0] best_q;
	logic [mgrt_pkg::WORD_W-1:0] min_q;
	logic [mgrt_pkg::WORD_W-1:0] max_q;
	logic vld_s1;
	logic take_s1;
	logic two_s1;
	logic out_valid_q;
	logic signed [mgrt_pkg::WORD_W-1:0] v_sg;
	logic signed [mgrt_pkg::WORD_W-1:0] min_sg;
	logic signed [mgrt_pkg::WORD_W-1:0] max_sg;

	// whole chain moves unless a finished result is still waiting
	assign adv = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign v_sg = tok_in.value;
	assign min_sg = min_q;
	assign max_sg = max_q;

	// running state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= mgrt_pkg::GAP_INIT;
			min_q <= mgrt_pkg::MIN_INIT;
			max_q <= mgrt_pkg::MAX_INIT;
			vld_s1 <= 1'b0;
			take_s1 <= 1'b0;
			two_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tok_in.vld;
			take_s1 <= tok_in.take;
			two_s1 <= tok_in.two;
			if (tok_in.vld && tok_in.take) begin
				if (tok_in.gap < best_q) begin
					best_q <= tok_in.gap;
				end
				if (v_sg < min_sg) begin
					min_q <= tok_in.value;
				end
				if (v_sg > max_sg) begin
					max_q <= tok_in.value;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted <= take_s1;
			overflow <= !take_s1;
			too_few <= !two_s1;
			shortest_span <= two_s1 ? best_q : '0;
			longest_span <= two_s1 ? (max_q - min_q) : '0;
		end
	end

endmodule

// ----- sv/min_gap_and_range_tracker.sv -----
// Minimum gap and range tracker. Each signed 32-bit number on the input channel
// is stored if the set holds fewer than min(limit, CAPACITY) numbers, else it is
// refused with overflow; one result beat per input beat gives the smallest gap
// between any two stored numbers and max minus min (both 0 with too_few while
// fewer than two are stored). A number walks a chain of CAPACITY cells, one cell
// each time the chain advances, each cell comparing it against the number it
// holds and the cell at the next free slot storing it; a new number enters every
// cycle unless the output stalls, so sustained rate is one beat per cycle. After
// the cells it passes the tail update and the result register. A stalled output
// holds the whole chain. limit is written through the apb port at address 0.

module min_gap_and_range_tracker #(
	parameter int CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mgrt_pkg::ADDR_W-1:0] paddr,
	input  logic [mgrt_pkg::DATA_W-1:0] pwdata,
	output logic [mgrt_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic accepted,
	output logic overflow,
	output logic too_few,
	output logic [31:0] shortest_span,
	output logic [31:0] longest_span
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > mgrt_pkg::LIMIT_W) ? CW : mgrt_pkg::LIMIT_W;

	logic [mgrt_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_nxt;
	logic [EW-1:0] lim_ext;
	logic [EW-1:0] eff;
	logic take;
	logic adv;
	logic in_acc;
	mgrt_pkg::tok_t tok [CAPACITY+1];
	logic [SW-1:0] slot [CAPACITY+1];

	mgrt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit_q(limit_q)
	);

	// admission: effective limit saturates at capacity
	assign lim_ext = EW'(limit_q);
	assign eff = (lim_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : lim_ext;
	assign take = EW'(count_q) < eff;
	assign cnt_nxt = count_q + CW'(take);
	assign in_ready = adv;
	assign in_acc = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= cnt_nxt;
		end
	end

	// beat entering the chain
	always_comb begin
		tok[0].vld = in_valid;
		tok[0].take = take;
		tok[0].two = cnt_nxt >= CW'(2);
		tok[0].value = value;
		tok[0].gap = mgrt_pkg::GAP_INIT;
		slot[0] = count_q[SW-1:0];
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mgrt_cell #(
			.CAPACITY(CAPACITY),
			.INDEX   (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (tok[i]),
			.slot_in(slot[i]),
			.tok_q  (tok[i+1]),
			.slot_q (slot[i+1])
		);
	end

	mgrt_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_in       (tok[CAPACITY]),
		.out_ready    (out_ready),
		.adv          (adv),
		.out_valid    (out_valid),
		.accepted     (accepted),
		.overflow     (overflow),
		.too_few      (too_few),
		.shortest_span(shortest_span),
		.longest_span (longest_span)
	);

endmodule

// ----- sv/mgrt_checker.sv -----
// port-level checks for the minimum gap and range tracker, bound to the top level
// depends on min_gap_and_range_tracker port names

module mgrt_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic out_valid,
	input  logic out_ready,
	input  logic accepted,
	input  logic overflow,
	input  logic too_few,
	input  logic [31:0] shortest_span,
	input  logic [31:0] longest_span
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shortest_span)
		&& $stable(longest_span) && $stable(accepted) && $stable(too_few))
		else $error("result beat changed while stalled");

	// stored and refused are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted != overflow))
		else $error("accepted and overflow disagree");

	// spans are zero with fewer than two numbers
	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_few |-> (shortest_span == 32'd0) && (longest_span == 32'd0))
		else $error("spans nonzero with too few numbers");

	// smallest gap never exceeds the range
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !too_few |-> shortest_span <= longest_span)
		else $error("shortest span above longest span");

endmodule

bind min_gap_and_range_tracker mgrt_checker u_mgrt_checker (.*);
